/* rtl/core/lsrci_pkg.sv */
// Shared constants and item types of the lattice site rank / checkerboard index block.
package lsrci_pkg;

  localparam int unsigned NUM_DIMS   = 4;
  localparam int unsigned MAX_EXTENT = 64;
  localparam int unsigned MAX_PARTS  = 4;

  localparam int unsigned COORD_W = 8;
  localparam int unsigned EXT_W   = 7;
  localparam int unsigned PARTS_W = 3;
  localparam int unsigned RANK_W  = 8;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned INDEX_W = 24;

  localparam int unsigned TABLE_DEPTH = 2 ** CODE_W;

  // configuration register map: extents first, then partition counts
  localparam int unsigned CFG_IDX_W      = 4;
  localparam int unsigned CFG_DATA_W     = 7;
  localparam int unsigned CFG_EXT_BASE   = 0;
  localparam int unsigned CFG_PARTS_BASE = NUM_DIMS;
  localparam int unsigned CFG_REG_COUNT  = 2 * NUM_DIMS;

  typedef enum logic {
    ACT_LOOKUP = 1'b0,
    ACT_LOAD   = 1'b1
  } action_e;

  typedef struct packed {
    logic               action;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
    logic [COORD_W-1:0] coord_t;
    logic [CODE_W-1:0]  map_code;
    logic [RANK_W-1:0]  map_rank;
  } site_req_t;

  typedef struct packed {
    logic [RANK_W-1:0]  rank;
    logic [INDEX_W-1:0] site_index;
    logic               range_error;
  } site_res_t;

endpackage

/* rtl/core/lattice_site_rank_and_checkerboard_index_top.sv */
// Top level: lattice site to rank and even-odd checkerboard index, with rank table.
//
// Usage:
//   Input items are taken on start_i whenever busy_o is low; busy_o never rises,
//   so one item can be accepted in every clock cycle.
//   A lookup item (action = lookup) yields one result when it leaves the pipeline:
//   res_strobe_o is high for exactly one cycle with res_o valid.
//   A load item (action = load) writes one entry of the rank table and yields no
//   result. Loads and lookups take effect strictly in acceptance order.
//   Throughput is one item per cycle; the latency is set by the four-stage index
//   pipeline (split, two multiply stages, final multiply plus table read) and the
//   output register.
//   The rank table is one synchronous memory of 256 entries; it is read and
//   written in the same pipeline stage, so no forwarding is needed.
//   Configuration: cfg_valid_i with cfg_index_i / cfg_data_i writes one register;
//   cfg_ready_o is always high. Write only while no lookup is in flight.
//   Reset: registers return to extent 4 and one partition per axis, the pipeline
//   empties and every table entry reads as rank 0 (per-entry valid flags clear).
//   The receiver cannot stall: a result is present for its one cycle only.
module lattice_site_rank_and_checkerboard_index_top
  import lsrci_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  site_req_t             in_i,
  output logic                  res_strobe_o,
  output site_res_t             res_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned DIM_W   = $clog2(NUM_DIMS);
  localparam int unsigned CMP_W   = EXT_W + PARTS_W;
  // partition number is the count of passed multiples of the extent
  localparam int unsigned NUM_CMP = (2 ** PARTS_W) - 2;
  localparam int unsigned LEX1_W  = 2 * EXT_W;
  localparam int unsigned LEX2_W  = 3 * EXT_W;
  localparam int unsigned LEX_W   = 4 * EXT_W;
  localparam int unsigned CODE1_W = 2 * PARTS_W;
  localparam int unsigned CODE2_W = 3 * PARTS_W;
  localparam int unsigned CODE3_W = 4 * PARTS_W;
  localparam int unsigned EXT_CAP_I   = (MAX_EXTENT > (2 ** EXT_W) - 1) ?
                                        (2 ** EXT_W) - 1 : MAX_EXTENT;
  localparam int unsigned PARTS_CAP_I = (MAX_PARTS > (2 ** PARTS_W) - 1) ?
                                        (2 ** PARTS_W) - 1 : MAX_PARTS;
  localparam logic [EXT_W-1:0]   EXT_CAP   = EXT_W'(EXT_CAP_I);
  localparam logic [PARTS_W-1:0] PARTS_CAP = PARTS_W'(PARTS_CAP_I);

  typedef struct packed {
    logic                               load;
    logic [CODE_W-1:0]                  mcode;
    logic [RANK_W-1:0]                  mrank;
    logic                               err;
    logic                               par;
    logic [NUM_DIMS-1:0][PARTS_W-1:0]   part;
    logic [NUM_DIMS-1:0][EXT_W-1:0]     loc;
  } s1_t;

  typedef struct packed {
    logic               load;
    logic [CODE_W-1:0]  mcode;
    logic [RANK_W-1:0]  mrank;
    logic               err;
    logic               par;
    logic [PARTS_W-1:0] px;
    logic [PARTS_W-1:0] py;
    logic [EXT_W-1:0]   lx;
    logic [EXT_W-1:0]   ly;
    logic [CODE1_W-1:0] code1;
    logic [LEX1_W-1:0]  lex1;
    logic [LEX1_W-1:0]  ns1;
  } s2_t;

  typedef struct packed {
    logic               load;
    logic [CODE_W-1:0]  mcode;
    logic [RANK_W-1:0]  mrank;
    logic               err;
    logic               par;
    logic [PARTS_W-1:0] px;
    logic [EXT_W-1:0]   lx;
    logic [CODE2_W-1:0] code2;
    logic [LEX2_W-1:0]  lex2;
    logic [LEX2_W-1:0]  ns2;
  } s3_t;

  typedef struct packed {
    logic               load;
    logic               err;
    logic               par;
    logic [LEX_W-1:0]   lex;
    logic [LEX_W-1:0]   ns;
  } s4_t;

  // configuration registers and their clamped views
  logic [NUM_DIMS-1:0][EXT_W-1:0]   ext_q;
  logic [NUM_DIMS-1:0][PARTS_W-1:0] parts_q;
  logic [NUM_DIMS-1:0][EXT_W-1:0]   ext_c;
  logic [NUM_DIMS-1:0][PARTS_W-1:0] parts_c;

  logic accept;
  logic v1_q, v2_q, v3_q, v4_q;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;
  s4_t  s4_d, s4_q;

  logic [CODE3_W-1:0] code3;
  logic [CODE_W-1:0]  rd_addr;
  logic               tbl_wr;

  logic [RANK_W-1:0]      rank_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] tbl_vld_q;
  logic [RANK_W-1:0]      rd_data_q;
  logic                   rd_vld_q;

  site_res_t res_d, res_q;
  logic      res_strobe_q;

  // the block never stalls: an item may enter every cycle
  assign busy_o       = 1'b0;
  assign cfg_ready_o  = 1'b1;
  assign accept       = start_i && !busy_o;
  assign res_o        = res_q;
  assign res_strobe_o = res_strobe_q;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < NUM_DIMS; d++) begin
        ext_q[d]   <= EXT_W'(4);
        parts_q[d] <= PARTS_W'(1);
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i < CFG_IDX_W'(CFG_PARTS_BASE)) begin
        ext_q[DIM_W'(cfg_index_i - CFG_IDX_W'(CFG_EXT_BASE))] <= cfg_data_i[EXT_W-1:0];
      end else if (cfg_index_i < CFG_IDX_W'(CFG_REG_COUNT)) begin
        parts_q[DIM_W'(cfg_index_i - CFG_IDX_W'(CFG_PARTS_BASE))] <= cfg_data_i[PARTS_W-1:0];
      end
    end
  end

  // Treat zero as one and cap at the supported maximum.
  always_comb begin
    for (int d = 0; d < NUM_DIMS; d++) begin
      if (ext_q[d] == '0) begin
        ext_c[d] = EXT_W'(1);
      end else if (ext_q[d] > EXT_CAP) begin
        ext_c[d] = EXT_CAP;
      end else begin
        ext_c[d] = ext_q[d];
      end
      if (parts_q[d] == '0) begin
        parts_c[d] = PARTS_W'(1);
      end else if (parts_q[d] > PARTS_CAP) begin
        parts_c[d] = PARTS_CAP;
      end else begin
        parts_c[d] = parts_q[d];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: split each coordinate into partition and local coordinate.
  // The partition number is small, so count the multiples of the extent that
  // the coordinate reaches instead of dividing.
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [NUM_DIMS-1:0][COORD_W-1:0] coord;
    logic [CMP_W-1:0]                 cw;
    logic [CMP_W-1:0]                 base;
    coord[0] = in_i.coord_x;
    coord[1] = in_i.coord_y;
    coord[2] = in_i.coord_z;
    coord[3] = in_i.coord_t;
    s1_d.load  = (in_i.action == ACT_LOAD);
    s1_d.mcode = in_i.map_code;
    s1_d.mrank = in_i.map_rank;
    s1_d.err   = 1'b0;
    s1_d.par   = 1'b0;
    for (int d = 0; d < NUM_DIMS; d++) begin
      cw = CMP_W'(coord[d]);
      if (cw >= CMP_W'(ext_c[d]) * CMP_W'(parts_c[d])) begin
        s1_d.err = 1'b1;
      end
      s1_d.part[d] = '0;
      for (int k = 1; k <= NUM_CMP; k++) begin
        if (cw >= CMP_W'(k) * CMP_W'(ext_c[d])) begin
          s1_d.part[d] = s1_d.part[d] + PARTS_W'(1);
        end
      end
      base        = CMP_W'(s1_d.part[d]) * CMP_W'(ext_c[d]);
      s1_d.loc[d] = EXT_W'(cw - base);
      // parity of part * ext + loc needs only the low bits
      s1_d.par    = s1_d.par ^ (s1_d.part[d][0] & ext_c[d][0]) ^ s1_d.loc[d][0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 2 to 4: Horner chains for the partition code, the lexicographic local
  // index and the local site count, one multiply per stage.
  // ---------------------------------------------------------------------------
  always_comb begin
    s2_d.load  = s1_q.load;
    s2_d.mcode = s1_q.mcode;
    s2_d.mrank = s1_q.mrank;
    s2_d.err   = s1_q.err;
    s2_d.par   = s1_q.par;
    s2_d.px    = s1_q.part[0];
    s2_d.py    = s1_q.part[1];
    s2_d.lx    = s1_q.loc[0];
    s2_d.ly    = s1_q.loc[1];
    s2_d.code1 = CODE1_W'(s1_q.part[2]) + CODE1_W'(parts_c[2]) * CODE1_W'(s1_q.part[3]);
    s2_d.lex1  = LEX1_W'(s1_q.loc[2]) + LEX1_W'(ext_c[2]) * LEX1_W'(s1_q.loc[3]);
    s2_d.ns1   = LEX1_W'(ext_c[0]) * LEX1_W'(ext_c[1]);
  end

  always_comb begin
    s3_d.load  = s2_q.load;
    s3_d.mcode = s2_q.mcode;
    s3_d.mrank = s2_q.mrank;
    s3_d.err   = s2_q.err;
    s3_d.par   = s2_q.par;
    s3_d.px    = s2_q.px;
    s3_d.lx    = s2_q.lx;
    s3_d.code2 = CODE2_W'(s2_q.py) + CODE2_W'(parts_c[1]) * CODE2_W'(s2_q.code1);
    s3_d.lex2  = LEX2_W'(s2_q.ly) + LEX2_W'(ext_c[1]) * LEX2_W'(s2_q.lex1);
    s3_d.ns2   = LEX2_W'(s2_q.ns1) * LEX2_W'(ext_c[2]);
  end

  always_comb begin
    s4_d.load = s3_q.load;
    s4_d.err  = s3_q.err;
    s4_d.par  = s3_q.par;
    s4_d.lex  = LEX_W'(s3_q.lx) + LEX_W'(ext_c[0]) * LEX_W'(s3_q.lex2);
    s4_d.ns   = LEX_W'(s3_q.ns2) * LEX_W'(ext_c[3]);
  end

  // Table port: a load writes here, a lookup reads here, in item order.
  assign code3   = CODE3_W'(s3_q.px) + CODE3_W'(parts_c[0]) * CODE3_W'(s3_q.code2);
  assign rd_addr = code3[CODE_W-1:0];
  assign tbl_wr  = v3_q && s3_q.load;

  // Pipeline control: advance every cycle, drop nothing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    s2_q <= s2_d;
    s3_q <= s3_d;
    s4_q <= s4_d;
  end

  // ---------------------------------------------------------------------------
  // Rank table memory; per-entry valid flags stand in for the all-zero reset.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (tbl_wr) begin
      rank_mem[s3_q.mcode] <= s3_q.mrank;
    end
    rd_data_q <= rank_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (tbl_wr) begin
        tbl_vld_q[s3_q.mcode] <= 1'b1;
      end
      rd_vld_q <= tbl_vld_q[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: final index and output register.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (s4_q.err) begin
      res_d.rank        = '0;
      res_d.site_index  = '0;
      res_d.range_error = 1'b1;
    end else begin
      res_d.rank        = rd_vld_q ? rd_data_q : '0;
      res_d.site_index  = INDEX_W'(s4_q.lex >> 1) +
                          (s4_q.par ? INDEX_W'(s4_q.ns >> 1) : INDEX_W'(0));
      res_d.range_error = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_strobe_q <= 1'b0;
    end else begin
      res_strobe_q <= v4_q && !s4_q.load;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

`ifndef SYNTH
  // every accepted lookup produces its result
  a_lookup_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (accept && in_i.action == ACT_LOOKUP) |-> ##5 res_strobe_o)
    else $error("lookup item lost");

  // no result without an accepted lookup in the pipeline
  a_result_has_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
      res_strobe_o |-> $past(accept && in_i.action == ACT_LOOKUP, 5))
    else $error("result without a lookup item");

  // an out-of-lattice site reports no rank and no index
  a_error_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (res_strobe_o && res_o.range_error) |-> (res_o.rank == '0 && res_o.site_index == '0))
    else $error("range error with nonzero fields");

  // a table write marks its entry valid on the next cycle
  a_write_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
      tbl_wr |=> tbl_vld_q[$past(s3_q.mcode)])
    else $error("table entry not marked valid after write");
`endif

endmodule
